// ===== rtl/sieve_and_prime_factor_engine_defines.svh =====
// Assertion macros shared by the checker files.
`ifndef SIEVE_AND_PRIME_FACTOR_ENGINE_DEFINES_SVH
`define SIEVE_AND_PRIME_FACTOR_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SPF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);

`endif

// ===== rtl/spf_pkg.sv =====
package spf_pkg;

   localparam int SIEVE_LIMIT_DEF = 1048576;
   localparam int PRIME_SLOTS_DEF = 131072;
   localparam int VALUE_BITS_DEF  = 40;

   localparam int ALU_BITS       = 64;
   localparam int MAX_ENTRIES    = 11;
   localparam int ENTRY_IDX_BITS = $clog2(MAX_ENTRIES);
   localparam int BOUND_BITS     = 20;
   localparam logic [BOUND_BITS-1:0] BOUND_RESET = 20'hFFFFF;

   localparam logic [1:0] KIND_ENTRY   = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_SIEVE   = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_ZERO      = 2'd1;
   localparam logic [1:0] ERR_NO_TABLE  = 2'd2;
   localparam logic [1:0] ERR_EXHAUSTED = 2'd3;

   localparam logic FUNC_BUILD  = 1'b0;
   localparam logic FUNC_FACTOR = 1'b1;

   typedef enum logic {ALU_MUL, ALU_DIV} alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [39:0] prime;
      logic [5:0]  exponent;
      logic [5:0]  count_all;
      logic [3:0]  count_distinct;
      logic [39:0] sum_distinct;
      logic [13:0] divisor_count;
      logic [62:0] divisor_sum;
      logic [39:0] totient;
      logic [1:0]  error;
      logic        last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLR, ST_SRD, ST_SCHK, ST_SSQ, ST_SMARK, ST_BDONE,
      ST_FRD, ST_FP, ST_FCMP, ST_DIV_GO, ST_DIV_WT, ST_PW_GO, ST_PW_WT,
      ST_REC, ST_DS_GO, ST_DS_WT, ST_TOT_GO, ST_TOT_WT, ST_EXH, ST_EXC,
      ST_TAIL, ST_EMIT, ST_ERR
   } state_type;

endpackage

// ===== rtl/sieve_and_prime_factor_engine.sv =====
// Prime sieve and trial-division factoriser. One transaction at a time: the
// input stalls from acceptance until the last result of that transaction has
// been handed to the output register. A build (func 0) first clears the mark
// memory over 0..B (B = sieve bound limited to SIEVE_LIMIT-1), then reads the
// mark of each integer 2..B, and for each prime stores it while slots remain,
// squares it and writes its composite marks. A factor transaction tries each
// stored prime in turn on the bit-serial divider (up to the prime whose square
// exceeds the remaining value); each further power of a factor adds a multiply
// and a divide, and each distinct factor found adds the divisor-sum multiply
// and the totient divide.
// A build returns one sieve result, marked last. A factor transaction returns
// factor entries (at most MAX_ENTRIES) in increasing prime order, then one
// summary marked last; an error returns that summary alone.
module sieve_and_prime_factor_engine #(
   parameter int SIEVE_LIMIT = spf_pkg::SIEVE_LIMIT_DEF,
   parameter int PRIME_SLOTS = spf_pkg::PRIME_SLOTS_DEF,
   parameter int VALUE_BITS  = spf_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [19:0] csr_sieve_bound,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [39:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [39:0] rsp_prime,
   output logic [5:0]  rsp_exponent,
   output logic [5:0]  rsp_count_all,
   output logic [3:0]  rsp_count_distinct,
   output logic [39:0] rsp_sum_distinct,
   output logic [13:0] rsp_divisor_count,
   output logic [62:0] rsp_divisor_sum,
   output logic [39:0] rsp_totient,
   output logic [1:0]  rsp_error,
   output logic        rsp_last
);
   localparam int SW   = $clog2(SIEVE_LIMIT);
   localparam int IW   = SW + 1;
   localparam int PW   = $clog2(PRIME_SLOTS);
   localparam int NW   = $clog2(PRIME_SLOTS + 1);
   localparam int VB   = VALUE_BITS;
   localparam int SQW  = 2 * IW;
   localparam int CW   = (VB > SQW) ? VB : SQW;
   localparam int AB   = spf_pkg::ALU_BITS;
   localparam int EW   = spf_pkg::ENTRY_IDX_BITS;
   localparam int NENT = spf_pkg::MAX_ENTRIES;

   // memories
   logic          marks_mem [SIEVE_LIMIT];
   logic [SW-1:0] plist_mem [PRIME_SLOTS];
   logic          mk_we, mk_wdata, mk_rdata;
   logic [SW-1:0] mk_waddr, mk_raddr;
   logic          pl_we;
   logic [PW-1:0] pl_waddr, pl_raddr;
   logic [SW-1:0] pl_wdata, pl_rdata;

   always_ff @(posedge clock) begin
      if (mk_we) marks_mem[mk_waddr] <= mk_wdata;
      mk_rdata <= marks_mem[mk_raddr];
   end

   always_ff @(posedge clock) begin
      if (pl_we) plist_mem[pl_waddr] <= pl_wdata;
      pl_rdata <= plist_mem[pl_raddr];
   end

   spf_pkg::state_type state_ff, state_in;
   logic [19:0]   bound_ff, bound_in;
   logic [SW-1:0] b_ff, b_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sq_ff, sq_in;
   logic [SW-1:0] p_ff, p_in;
   logic [VB-1:0] n_ff, n_in;
   logic [VB-1:0] f_ff, f_in;
   logic [VB-1:0] tot_ff, tot_in;
   logic [5:0]    e_ff, e_in;
   logic [AB-1:0] pw_ff, pw_in;
   logic [AB-1:0] term_ff, term_in;
   logic [AB-1:0] dsum_ff, dsum_in;
   logic          tail_ff, tail_in;
   logic [3:0]    nf_ff, nf_in;
   logic [5:0]    call_ff, call_in;
   logic [39:0]   sdist_ff, sdist_in;
   logic [13:0]   dcnt_ff, dcnt_in;
   logic [1:0]    err_ff, err_in;
   logic [3:0]    k_ff, k_in;
   logic [VB-1:0] ent_p_ff [NENT];
   logic [5:0]    ent_e_ff [NENT];
   logic          ent_we;
   logic [3:0]    emit_n;

   spf_pkg::alu_ctl_type alu_ctl;
   spf_pkg::alu_sts_type alu_sts;
   logic [AB-1:0] alu_a, alu_b, alu_prod;
   logic [VB-1:0] alu_quo, alu_rem;

   logic             oq_valid, oq_ready;
   spf_pkg::rsp_type oq_data, rsp_data;
   logic             accept;
   logic [VB-1:0]    n_req;

   spf_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
      .clock     (clock),
      .reset     (reset),
      .ctl       (alu_ctl),
      .opa       (alu_a),
      .opb       (alu_b),
      .sts       (alu_sts),
      .quotient  (alu_quo),
      .remainder (alu_rem),
      .product   (alu_prod)
   );

   spf_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (oq_valid),
      .in_ready  (oq_ready),
      .in_data   (oq_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = (state_ff != spf_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign n_req     = VB'(req_value);
   assign bound_in  = csr_write_en ? csr_sieve_bound : bound_ff;
   assign emit_n    = (nf_ff < 4'(NENT)) ? nf_ff : 4'(NENT);

   always_comb begin
      state_in = state_ff;
      b_in     = b_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      sq_in    = sq_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      f_in     = f_ff;
      tot_in   = tot_ff;
      e_in     = e_ff;
      pw_in    = pw_ff;
      term_in  = term_ff;
      dsum_in  = dsum_ff;
      tail_in  = tail_ff;
      nf_in    = nf_ff;
      call_in  = call_ff;
      sdist_in = sdist_ff;
      dcnt_in  = dcnt_ff;
      err_in   = err_ff;
      k_in     = k_ff;
      ent_we   = 1'b0;
      mk_we    = 1'b0;
      mk_wdata = 1'b0;
      mk_waddr = i_ff[SW-1:0];
      mk_raddr = i_ff[SW-1:0];
      pl_we    = 1'b0;
      pl_waddr = count_ff[PW-1:0];
      pl_wdata = i_ff[SW-1:0];
      pl_raddr = idx_ff[PW-1:0];
      alu_ctl.start = 1'b0;
      alu_ctl.op    = spf_pkg::ALU_DIV;
      alu_a    = AB'(n_ff);
      alu_b    = AB'(p_ff);
      oq_valid = 1'b0;
      oq_data  = '0;

      unique case (state_ff)
         spf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == spf_pkg::FUNC_BUILD) begin
                  b_in = (32'(bound_ff) > 32'(SIEVE_LIMIT - 1)) ?
                         SW'(SIEVE_LIMIT - 1) : SW'(bound_ff);
                  i_in     = '0;
                  count_in = '0;
                  state_in = spf_pkg::ST_CLR;
               end else if (n_req == '0) begin
                  err_in   = spf_pkg::ERR_ZERO;
                  state_in = spf_pkg::ST_ERR;
               end else if (count_ff == '0) begin
                  err_in   = spf_pkg::ERR_NO_TABLE;
                  state_in = spf_pkg::ST_ERR;
               end else begin
                  n_in     = n_req;
                  tot_in   = n_req;
                  idx_in   = '0;
                  nf_in    = '0;
                  call_in  = '0;
                  sdist_in = '0;
                  dcnt_in  = 14'd1;
                  dsum_in  = AB'(1);
                  state_in = spf_pkg::ST_FRD;
               end
            end
         end
         // clearing pass over 0..B
         spf_pkg::ST_CLR: begin
            mk_we = 1'b1;
            if (i_ff == IW'(b_ff)) begin
               i_in     = IW'(2);
               state_in = spf_pkg::ST_SRD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         spf_pkg::ST_SRD: begin
            if (i_ff > IW'(b_ff)) state_in = spf_pkg::ST_BDONE;
            else state_in = spf_pkg::ST_SCHK;
         end
         spf_pkg::ST_SCHK: begin
            if (mk_rdata) begin
               i_in     = i_ff + 1'b1;
               state_in = spf_pkg::ST_SRD;
            end else begin
               if (count_ff != NW'(PRIME_SLOTS)) begin
                  pl_we    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               sq_in    = CW'(i_ff) * CW'(i_ff);
               state_in = spf_pkg::ST_SSQ;
            end
         end
         spf_pkg::ST_SSQ: begin
            if (sq_ff <= CW'(b_ff)) begin
               j_in     = IW'(sq_ff);
               state_in = spf_pkg::ST_SMARK;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = spf_pkg::ST_SRD;
            end
         end
         spf_pkg::ST_SMARK: begin
            mk_we    = 1'b1;
            mk_wdata = 1'b1;
            mk_waddr = j_ff[SW-1:0];
            j_in     = j_ff + i_ff;
            if (j_in > IW'(b_ff)) begin
               i_in     = i_ff + 1'b1;
               state_in = spf_pkg::ST_SRD;
            end
         end
         spf_pkg::ST_BDONE: begin
            oq_valid      = 1'b1;
            oq_data.kind  = spf_pkg::KIND_SIEVE;
            oq_data.prime = 40'(count_ff);
            oq_data.last  = 1'b1;
            if (oq_ready) state_in = spf_pkg::ST_IDLE;
         end
         spf_pkg::ST_FRD: begin
            if (idx_ff == count_ff) state_in = spf_pkg::ST_EXH;
            else state_in = spf_pkg::ST_FP;
         end
         spf_pkg::ST_FP: begin
            p_in     = pl_rdata;
            sq_in    = CW'(pl_rdata) * CW'(pl_rdata);
            state_in = spf_pkg::ST_FCMP;
         end
         spf_pkg::ST_FCMP: begin
            if (sq_ff > CW'(n_ff)) begin
               state_in = spf_pkg::ST_TAIL;
            end else begin
               e_in     = '0;
               pw_in    = AB'(1);
               term_in  = AB'(1);
               state_in = spf_pkg::ST_DIV_GO;
            end
         end
         spf_pkg::ST_DIV_GO: begin
            alu_ctl.start = 1'b1;
            state_in      = spf_pkg::ST_DIV_WT;
         end
         spf_pkg::ST_DIV_WT: begin
            if (alu_sts.done) begin
               if (alu_rem == '0) begin
                  n_in     = alu_quo;
                  e_in     = e_ff + 1'b1;
                  state_in = spf_pkg::ST_PW_GO;
               end else if (e_ff != '0) begin
                  f_in     = VB'(p_ff);
                  tail_in  = 1'b0;
                  state_in = spf_pkg::ST_REC;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = spf_pkg::ST_FRD;
               end
            end
         end
         spf_pkg::ST_PW_GO: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op    = spf_pkg::ALU_MUL;
            alu_a         = pw_ff;
            state_in      = spf_pkg::ST_PW_WT;
         end
         spf_pkg::ST_PW_WT: begin
            if (alu_sts.done) begin
               pw_in    = alu_prod;
               term_in  = term_ff + alu_prod;
               state_in = spf_pkg::ST_DIV_GO;
            end
         end
         // fold one distinct factor into the summary
         spf_pkg::ST_REC: begin
            ent_we   = (nf_ff < 4'(NENT));
            nf_in    = nf_ff + 1'b1;
            call_in  = call_ff + e_ff;
            sdist_in = sdist_ff + 40'(f_ff);
            dcnt_in  = 14'(dcnt_ff * (14'(e_ff) + 14'd1));
            state_in = spf_pkg::ST_DS_GO;
         end
         spf_pkg::ST_DS_GO: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op    = spf_pkg::ALU_MUL;
            alu_a         = dsum_ff;
            alu_b         = term_ff;
            state_in      = spf_pkg::ST_DS_WT;
         end
         spf_pkg::ST_DS_WT: begin
            if (alu_sts.done) begin
               dsum_in  = alu_prod;
               state_in = spf_pkg::ST_TOT_GO;
            end
         end
         spf_pkg::ST_TOT_GO: begin
            alu_ctl.start = 1'b1;
            alu_a         = AB'(tot_ff);
            alu_b         = AB'(f_ff);
            state_in      = spf_pkg::ST_TOT_WT;
         end
         spf_pkg::ST_TOT_WT: begin
            if (alu_sts.done) begin
               tot_in = tot_ff - alu_quo;
               if (tail_ff) begin
                  k_in     = '0;
                  state_in = spf_pkg::ST_EMIT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = spf_pkg::ST_FRD;
               end
            end
         end
         // whole table tried: p holds the largest stored prime
         spf_pkg::ST_EXH: begin
            sq_in    = (CW'(p_ff) + 1'b1) * (CW'(p_ff) + 1'b1);
            state_in = spf_pkg::ST_EXC;
         end
         spf_pkg::ST_EXC: begin
            if (n_ff > VB'(1) && CW'(n_ff) >= sq_ff) begin
               err_in   = spf_pkg::ERR_EXHAUSTED;
               state_in = spf_pkg::ST_ERR;
            end else begin
               state_in = spf_pkg::ST_TAIL;
            end
         end
         spf_pkg::ST_TAIL: begin
            if (n_ff > VB'(1)) begin
               f_in     = n_ff;
               e_in     = 6'd1;
               term_in  = AB'(n_ff) + 1'b1;
               tail_in  = 1'b1;
               state_in = spf_pkg::ST_REC;
            end else begin
               k_in     = '0;
               state_in = spf_pkg::ST_EMIT;
            end
         end
         spf_pkg::ST_EMIT: begin
            oq_valid = 1'b1;
            if (k_ff < emit_n) begin
               oq_data.kind     = spf_pkg::KIND_ENTRY;
               oq_data.prime    = 40'(ent_p_ff[EW'(k_ff)]);
               oq_data.exponent = ent_e_ff[EW'(k_ff)];
               if (oq_ready) k_in = k_ff + 1'b1;
            end else begin
               oq_data.kind           = spf_pkg::KIND_SUMMARY;
               oq_data.count_all      = call_ff;
               oq_data.count_distinct = nf_ff;
               oq_data.sum_distinct   = sdist_ff;
               oq_data.divisor_count  = dcnt_ff;
               oq_data.divisor_sum    = 63'(dsum_ff);
               oq_data.totient        = 40'(tot_ff);
               oq_data.last           = 1'b1;
               if (oq_ready) state_in = spf_pkg::ST_IDLE;
            end
         end
         spf_pkg::ST_ERR: begin
            oq_valid      = 1'b1;
            oq_data.kind  = spf_pkg::KIND_SUMMARY;
            oq_data.error = err_ff;
            oq_data.last  = 1'b1;
            if (oq_ready) state_in = spf_pkg::ST_IDLE;
         end
         default: state_in = spf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spf_pkg::ST_IDLE;
         bound_ff <= spf_pkg::BOUND_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         bound_ff <= bound_in;
         count_ff <= count_in;
      end
      b_ff     <= b_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      idx_ff   <= idx_in;
      sq_ff    <= sq_in;
      p_ff     <= p_in;
      n_ff     <= n_in;
      f_ff     <= f_in;
      tot_ff   <= tot_in;
      e_ff     <= e_in;
      pw_ff    <= pw_in;
      term_ff  <= term_in;
      dsum_ff  <= dsum_in;
      tail_ff  <= tail_in;
      nf_ff    <= nf_in;
      call_ff  <= call_in;
      sdist_ff <= sdist_in;
      dcnt_ff  <= dcnt_in;
      err_ff   <= err_in;
      k_ff     <= k_in;
      if (ent_we) begin
         ent_p_ff[EW'(nf_ff)] <= f_ff;
         ent_e_ff[EW'(nf_ff)] <= e_ff;
      end
   end

   assign rsp_kind           = rsp_data.kind;
   assign rsp_prime          = rsp_data.prime;
   assign rsp_exponent       = rsp_data.exponent;
   assign rsp_count_all      = rsp_data.count_all;
   assign rsp_count_distinct = rsp_data.count_distinct;
   assign rsp_sum_distinct   = rsp_data.sum_distinct;
   assign rsp_divisor_count  = rsp_data.divisor_count;
   assign rsp_divisor_sum    = rsp_data.divisor_sum;
   assign rsp_totient        = rsp_data.totient;
   assign rsp_error          = rsp_data.error;
   assign rsp_last           = rsp_data.last;

endmodule

// ===== rtl/spf_alu.sv =====
module spf_alu #(
   parameter int VALUE_BITS = spf_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spf_pkg::alu_ctl_type         ctl,
   input  logic [spf_pkg::ALU_BITS-1:0] opa,
   input  logic [spf_pkg::ALU_BITS-1:0] opb,
   output spf_pkg::alu_sts_type         sts,
   output logic [VALUE_BITS-1:0]        quotient,
   output logic [VALUE_BITS-1:0]        remainder,
   output logic [spf_pkg::ALU_BITS-1:0] product
);
   localparam int VB = VALUE_BITS;
   localparam int CB = $clog2(VB);
   localparam int AB = spf_pkg::ALU_BITS;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   spf_pkg::alu_op_type op_ff, op_in;
   logic [CB-1:0]       cnt_ff, cnt_in;
   logic [VB-1:0]       rem_ff, rem_in;
   logic [VB-1:0]       quo_ff, quo_in;
   logic [VB-1:0]       dvs_ff, dvs_in;
   logic [AB-1:0]       acc_ff, acc_in;
   logic [AB-1:0]       mc_ff, mc_in;
   logic [AB-1:0]       mp_ff, mp_in;
   logic [VB:0]         trial;
   logic                fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      trial   = {rem_ff, quo_ff[VB-1]};
      fits    = trial >= {1'b0, dvs_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = VB'(opa);
         dvs_in  = VB'(opb);
         acc_in  = '0;
         mc_in   = opa;
         mp_in   = opb;
      end else if (busy_ff) begin
         unique case (op_ff)
            spf_pkg::ALU_DIV: begin
               // one restoring step per cycle
               rem_in = fits ? VB'(trial - {1'b0, dvs_ff}) : VB'(trial);
               quo_in = {quo_ff[VB-2:0], fits};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CB'(VB - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            spf_pkg::ALU_MUL: begin
               if (mp_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (mp_ff[0]) acc_in = acc_ff + mc_ff;
                  mc_in = {mc_ff[AB-2:0], 1'b0};
                  mp_in = {1'b0, mp_ff[AB-1:1]};
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign product   = acc_ff;

endmodule

// ===== rtl/spf_outq.sv =====
module spf_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  spf_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output spf_pkg::rsp_type out_data
);
   logic             valid_ff, valid_in;
   spf_pkg::rsp_type data_ff, data_in;

   always_comb begin
      in_ready = !valid_ff || !out_stall;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) data_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/spf_checker.sv =====
`include "sieve_and_prime_factor_engine_defines.svh"

module spf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [1:0]  rsp_error,
   input logic        rsp_last
);
   // hold a stalled transaction
   `SPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_last), "stalled result changed")

   `SPF_ASSERT(a_entry_not_last, clock, reset, rsp_valid && rsp_kind == spf_pkg::KIND_ENTRY |-> !rsp_last, "factor entry marked last")

   `SPF_ASSERT(a_err_summary, clock, reset, rsp_valid && rsp_error != spf_pkg::ERR_NONE |-> rsp_kind == spf_pkg::KIND_SUMMARY && rsp_last, "error not on a final summary")

   `SPF_ASSERT(a_busy_mid_item, clock, reset, rsp_valid && !rsp_last |-> req_stall, "input taken while results still due")

endmodule

bind sieve_and_prime_factor_engine spf_checker u_spf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_kind  (rsp_kind),
   .rsp_error (rsp_error),
   .rsp_last  (rsp_last)
);

// ===== tb/sv/spf_scoreboard.sv =====
module spf_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [19:0] csr_sieve_bound,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_func,
   input  logic [39:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [39:0] rsp_prime,
   input  logic [5:0]  rsp_exponent,
   input  logic [5:0]  rsp_count_all,
   input  logic [3:0]  rsp_count_distinct,
   input  logic [39:0] rsp_sum_distinct,
   input  logic [13:0] rsp_divisor_count,
   input  logic [62:0] rsp_divisor_sum,
   input  logic [39:0] rsp_totient,
   input  logic [1:0]  rsp_error,
   input  logic        rsp_last,
   output int          fail_count,
   output int          results_due
);

   logic [spf_pkg::BOUND_BITS-1:0] bound_q;
   int unsigned                    prime_table[$];
   bit                             table_ok;
   spf_pkg::rsp_type               expected_rsp[$];

   task automatic add_expected(spf_pkg::rsp_type r);
      expected_rsp = {expected_rsp, r};
   endtask

   task automatic add_error(logic [1:0] code);
      spf_pkg::rsp_type r;
      r = '0;
      r.kind  = spf_pkg::KIND_SUMMARY;
      r.error = code;
      r.last  = 1'b1;
      add_expected(r);
   endtask

   task automatic run_sieve();
      longint           b;
      bit               marks[];
      spf_pkg::rsp_type r;
      b = bound_q;
      if (b > spf_pkg::SIEVE_LIMIT_DEF - 1) begin
         b = spf_pkg::SIEVE_LIMIT_DEF - 1;
      end
      marks = new[b + 1];
      prime_table.delete();
      for (longint i = 2; i <= b; i++) begin
         if (!marks[i]) begin
            for (longint j = i * i; j <= b; j += i) marks[j] = 1'b1;
            if (prime_table.size() < spf_pkg::PRIME_SLOTS_DEF) begin
               prime_table = {prime_table, 32'(i)};
            end
         end
      end
      table_ok = prime_table.size() > 0;
      r = '0;
      r.kind  = spf_pkg::KIND_SIEVE;
      r.prime = 40'(prime_table.size());
      r.last  = 1'b1;
      add_expected(r);
   endtask

   task automatic factorise(logic [39:0] value);
      longint unsigned  n, p, e, term, pw, plast;
      longint unsigned  all_cnt, sdist, dcnt, dsum, tot;
      longint unsigned  fac_p[$], fac_e[$];
      int               idx;
      spf_pkg::rsp_type r;
      n = value;
      idx = 0;
      if (n == 0) begin
         add_error(spf_pkg::ERR_ZERO);
         return;
      end
      if (!table_ok) begin
         add_error(spf_pkg::ERR_NO_TABLE);
         return;
      end
      while (idx < prime_table.size()) begin
         p = prime_table[idx];
         if (p * p > n) break;
         if (n % p == 0) begin
            e = 0;
            while (n % p == 0) begin
               n = n / p;
               e++;
            end
            fac_p = {fac_p, p};
            fac_e = {fac_e, e};
         end
         idx++;
      end
      plast = prime_table[prime_table.size() - 1];
      if (idx == prime_table.size() && n > 1 && n >= (plast + 1) * (plast + 1)) begin
         add_error(spf_pkg::ERR_EXHAUSTED);
         return;
      end
      if (n > 1) begin
         fac_p = {fac_p, n};
         fac_e = {fac_e, 64'd1};
      end
      all_cnt = 0; sdist = 0; dcnt = 1; dsum = 1; tot = value;
      foreach (fac_p[k]) begin
         term = 1;
         pw = 1;
         all_cnt += fac_e[k];
         sdist += fac_p[k];
         dcnt *= fac_e[k] + 1;
         for (int q = 0; q < fac_e[k]; q++) begin
            pw *= fac_p[k];
            term += pw;
         end
         dsum *= term;
         tot -= tot / fac_p[k];
      end
      foreach (fac_p[k]) begin
         if (k < spf_pkg::MAX_ENTRIES) begin
            r = '0;
            r.kind     = spf_pkg::KIND_ENTRY;
            r.prime    = 40'(fac_p[k]);
            r.exponent = 6'(fac_e[k]);
            add_expected(r);
         end
      end
      r = '0;
      r.kind           = spf_pkg::KIND_SUMMARY;
      r.count_all      = 6'(all_cnt);
      r.count_distinct = 4'(fac_p.size());
      r.sum_distinct   = 40'(sdist);
      r.divisor_count  = 14'(dcnt);
      r.divisor_sum    = 63'(dsum);
      r.totient        = 40'(tot);
      r.last           = 1'b1;
      add_expected(r);
   endtask

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      spf_pkg::rsp_type exp_r;
      if (reset) begin
         bound_q = spf_pkg::BOUND_RESET;
         prime_table.delete();
         table_ok = 1'b0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_write_en) bound_q = csr_sieve_bound;
         if (req_valid && !req_stall) begin
            if (req_func == spf_pkg::FUNC_BUILD) run_sieve();
            else factorise(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count++;
            end else begin
               exp_r = expected_rsp.pop_front();
               check_field("kind", exp_r.kind, rsp_kind);
               check_field("prime", exp_r.prime, rsp_prime);
               check_field("exponent", exp_r.exponent, rsp_exponent);
               check_field("count_all", exp_r.count_all, rsp_count_all);
               check_field("count_distinct", exp_r.count_distinct, rsp_count_distinct);
               check_field("sum_distinct", exp_r.sum_distinct, rsp_sum_distinct);
               check_field("divisor_count", exp_r.divisor_count, rsp_divisor_count);
               check_field("divisor_sum", exp_r.divisor_sum, rsp_divisor_sum);
               check_field("totient", exp_r.totient, rsp_totient);
               check_field("error", exp_r.error, rsp_error);
               check_field("last", exp_r.last, rsp_last);
            end
         end
      end
      results_due = expected_rsp.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;

   localparam int STALL_LIMIT = 500000;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [19:0] csr_sieve_bound;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [39:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [39:0] rsp_prime;
   logic [5:0]  rsp_exponent;
   logic [5:0]  rsp_count_all;
   logic [3:0]  rsp_count_distinct;
   logic [39:0] rsp_sum_distinct;
   logic [13:0] rsp_divisor_count;
   logic [62:0] rsp_divisor_sum;
   logic [39:0] rsp_totient;
   logic [1:0]  rsp_error;
   logic        rsp_last;

   int fail_count;
   int results_due;
   int idle_pct;
   int stall_pct;
   int hold_cycles;
   int quiet_cycles;

   const int small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

   sieve_and_prime_factor_engine u_top (.*);

   spf_scoreboard u_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: long hold-off first when requested, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(logic func, logic [39:0] value);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_value <= {8'($urandom), 32'($urandom)};
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // drain, let the engine settle, then write the bound
   task automatic set_bound(logic [19:0] bound);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_due == 0);
      repeat (20) @(negedge clock);
      csr_write_en    <= 1'b1;
      csr_sieve_bound <= bound;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [39:0] pick_value();
      longint unsigned v, p;
      int              sel;
      sel = $urandom_range(99);
      if (sel < 20) return {8'($urandom), 32'($urandom)};
      if (sel < 35) return 40'($urandom_range(65535));
      v = 1;
      repeat ($urandom_range(1, 6)) begin
         p = small_primes[$urandom_range(11)];
         repeat ($urandom_range(1, 4)) if (v * p < (64'd1 << 40)) v *= p;
      end
      if ($urandom_range(1)) begin
         p = $urandom_range(2, 5000);
         if (v * p < (64'd1 << 40)) v *= p;
      end
      return 40'(v);
   endfunction

   initial begin
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_sieve_bound = '0;
      req_valid       = 1'b0;
      req_func        = spf_pkg::FUNC_BUILD;
      req_value       = '0;
      rsp_stall       = 1'b0;
      idle_pct        = 0;
      stall_pct       = 0;
      hold_cycles     = 0;
      quiet_cycles    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no table yet, and a zero value
      send(spf_pkg::FUNC_FACTOR, 40'd5);
      send(spf_pkg::FUNC_FACTOR, 40'd0);
      // bound below two leaves the table empty
      set_bound(20'd1);
      send(spf_pkg::FUNC_BUILD, '0);
      send(spf_pkg::FUNC_FACTOR, 40'd7);
      set_bound(20'd2);
      send(spf_pkg::FUNC_BUILD, '0);
      send(spf_pkg::FUNC_FACTOR, 40'd8);
      send(spf_pkg::FUNC_FACTOR, 40'd9);
      send(spf_pkg::FUNC_FACTOR, 40'd3);
      set_bound(20'd100);
      send(spf_pkg::FUNC_BUILD, '0);
      send(spf_pkg::FUNC_FACTOR, 40'd1);
      send(spf_pkg::FUNC_FACTOR, 40'h80_0000_0000);
      send(spf_pkg::FUNC_FACTOR, 40'hFF_FFFF_FFFF);
      send(spf_pkg::FUNC_FACTOR, 40'd200560490130);
      send(spf_pkg::FUNC_FACTOR, 40'd10403);
      send(spf_pkg::FUNC_FACTOR, 40'd9409);
      send(spf_pkg::FUNC_FACTOR, 40'd96);
      // widest bound: factor only, against the table already built
      set_bound(20'hFFFFF);
      send(spf_pkg::FUNC_FACTOR, 40'd1000000007);
      send(spf_pkg::FUNC_FACTOR, 40'd360);
      set_bound(20'd0);
      send(spf_pkg::FUNC_BUILD, '0);
      send(spf_pkg::FUNC_FACTOR, 40'd12);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 11 : 0;
         stall_pct = (phase == 2) ? 51 : (phase == 3) ? 11 : 0;
         set_bound(20'($urandom_range(2, 700)));
         send(spf_pkg::FUNC_BUILD, '0);
         // hold the receiver off so the engine backs up onto its input
         if (phase == 0) hold_cycles = 3000;
         repeat (20) begin
            if ($urandom_range(99) < 5) begin
               send(spf_pkg::FUNC_BUILD, {8'($urandom), 32'($urandom)});
            end else begin
               send(spf_pkg::FUNC_FACTOR, pick_value());
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_due == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
